// ===== rtl/ra_pkg.sv =====
// types and constants shared by the region allocator modules
// no dependencies
package ra_pkg;

  localparam int unsigned AddrW = 24;
  localparam int unsigned LenW  = 25;

  localparam logic [LenW-1:0]  ADDR_SPACE      = 25'h1000000;
  localparam logic [AddrW-1:0] RST_HEAP_BASE   = 24'h801000;
  localparam logic [LenW-1:0]  RST_HEAP_LENGTH = 25'h07FF000;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } ra_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } ra_status_e;

  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_HEAP_LENGTH = 1'b1;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_INIT, S_DONE,
    S_A_RD, S_A_CHK, S_A_END, S_A_CARVE,
    S_RM_RD, S_RM_WR,
    S_F_URD, S_F_UCHK, S_F_END, S_F_RD, S_F_CHK,
    S_F_MLO, S_F_MHI, S_F_MHI2, S_F_MHI3,
    S_F_INS, S_INS_RD, S_INS_WR,
    S_REL_RD, S_REL_WR
  } ra_state_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [LenW-1:0]  request_bytes;
    logic [AddrW-1:0] block_address;
  } ra_in_t;

  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    logic [1:0]       status;
  } ra_out_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
  } ra_ent_t;

  typedef struct packed {
    logic [LenW-1:0] a;
    logic [LenW-1:0] b;
    logic            sub;
    logic [LenW-1:0] c;
    logic [LenW-1:0] d;
    logic [LenW-1:0] e;
  } ra_alu_req_t;

  typedef struct packed {
    logic [LenW-1:0] sum;
    logic            lt;
    logic            eq;
    logic            sum_eq;
  } ra_alu_rsp_t;

endpackage

// ===== rtl/ra_alu.sv =====
// shared add/subtract and compare unit of the region allocator
// depends on ra_pkg
module ra_alu (
  input  ra_pkg::ra_alu_req_t req_i,
  output ra_pkg::ra_alu_rsp_t rsp_o
);
  import ra_pkg::*;

  logic [LenW-1:0] sum;

  assign sum           = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
  assign rsp_o.sum     = sum;
  assign rsp_o.lt      = req_i.c < req_i.d;
  assign rsp_o.eq      = req_i.c == req_i.d;
  assign rsp_o.sum_eq  = sum == req_i.e;

endmodule

// ===== rtl/ra_tbl.sv =====
// region table memory, one write and one registered read port
// depends on ra_pkg
module ra_tbl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ra_pkg::ra_ent_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output ra_pkg::ra_ent_t rdata_o
);
  import ra_pkg::*;

  ra_ent_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/region_allocator_with_coalescing.sv =====
// top level of the region allocator: sequencer, counters, beat registers
// depends on ra_pkg, ra_alu, ra_tbl
//
// channel | direction | handshake              | payload
// in      | in        | in_valid_i/in_ready_o   | in_data_i  (ra_in_t)
// out     | out       | out_valid_o/out_ready_i | out_data_o (ra_out_t)
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item at a time; allocate scans every free entry and may shift the free
// table down, free scans the used table, then the free table, and may shift it
// either way; each of the two tables has a single registered read port
// after reset the boot state writes the initial free region before the first beat
// a result waiting on out does not stop the next beat being taken
module region_allocator_with_coalescing #(
  parameter int unsigned FREE_ENTRIES = 64,
  parameter int unsigned USED_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ra_pkg::ra_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ra_pkg::ra_out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [24:0]     cfg_data_i
);
  import ra_pkg::*;

  localparam int unsigned FAW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned UAW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned UCW = $clog2(USED_ENTRIES + 1);
  localparam int unsigned IW  = (FCW > UCW) ? FCW : UCW;

  ra_state_e state_q, state_d;
  logic [AddrW-1:0] base_q;
  logic [LenW-1:0]  hlen_q;
  logic [1:0]       op_q, op_d;
  logic [LenW-1:0]  req_q, req_d;
  logic [AddrW-1:0] blk_q, blk_d;
  logic [FCW-1:0]   fc_q, fc_d;
  logic [UCW-1:0]   uc_q, uc_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [FCW-1:0]   k_q, k_d;
  logic [UAW-1:0]   u_q, u_d;
  logic [FAW-1:0]   pick_q, pick_d;
  logic             found_q, found_d;
  ra_ent_t          cur_q, cur_d;
  logic [LenW-1:0]  tmp_q, tmp_d;
  logic [LenW-1:0]  nxt_q, nxt_d;
  logic [LenW-1:0]  end_q, end_d;
  logic [AddrW-1:0] grant_q, grant_d;
  logic [1:0]       status_q, status_d;
  logic             out_valid_q, out_valid_d;
  ra_out_t          out_q, out_d;

  ra_alu_req_t alu_req;
  ra_alu_rsp_t alu_rsp;

  logic            f_we, u_we;
  logic [FAW-1:0]  f_waddr, f_raddr;
  logic [UAW-1:0]  u_waddr, u_raddr;
  ra_ent_t         f_wdata, u_wdata, f_rdata, u_rdata;
  logic [IW:0]     idx_inc;

  ra_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ra_tbl #(.DEPTH(FREE_ENTRIES), .AW(FAW)) u_free_tbl (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  ra_tbl #(.DEPTH(USED_ENTRIES), .AW(UAW)) u_used_tbl (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx_inc     = {1'b0, idx_q} + 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RST_HEAP_BASE;
      hlen_q <= RST_HEAP_LENGTH;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_HEAP_BASE) begin
        base_q <= cfg_data_i[AddrW-1:0];
      end else begin
        hlen_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BOOT;
      fc_q        <= FCW'(1);
      uc_q        <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      uc_q        <= uc_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    req_q    <= req_d;
    blk_q    <= blk_d;
    k_q      <= k_d;
    u_q      <= u_d;
    pick_q   <= pick_d;
    cur_q    <= cur_d;
    tmp_q    <= tmp_d;
    nxt_q    <= nxt_d;
    end_q    <= end_d;
    grant_q  <= grant_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    req_d       = req_q;
    blk_d       = blk_q;
    fc_d        = fc_q;
    uc_d        = uc_q;
    idx_d       = idx_q;
    k_d         = k_q;
    u_d         = u_q;
    pick_d      = pick_q;
    found_d     = found_q;
    cur_d       = cur_q;
    tmp_d       = tmp_q;
    nxt_d       = nxt_q;
    end_d       = end_q;
    grant_d     = grant_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    alu_req     = '0;
    f_we        = 1'b0;
    f_waddr     = idx_q[FAW-1:0];
    f_wdata     = cur_q;
    f_raddr     = idx_q[FAW-1:0];
    u_we        = 1'b0;
    u_waddr     = uc_q[UAW-1:0];
    u_wdata     = cur_q;
    u_raddr     = idx_q[UAW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_BOOT: begin
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = '{start: RST_HEAP_BASE, len: RST_HEAP_LENGTH};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i.opcode;
          req_d    = in_data_i.request_bytes;
          blk_d    = in_data_i.block_address;
          grant_d  = '0;
          status_d = ST_OK;
          idx_d    = '0;
          found_d  = 1'b0;
          case (in_data_i.opcode)
            OP_INIT:  state_d = S_INIT;
            OP_ALLOC: begin
              if (in_data_i.request_bytes == '0) begin
                status_d = ST_NO_FIT;
                state_d  = S_DONE;
              end else begin
                state_d = S_A_RD;
              end
            end
            OP_FREE:  state_d = S_F_URD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        // saturate the heap at the top of the address space
        alu_req.a   = ADDR_SPACE;
        alu_req.b   = {1'b0, base_q};
        alu_req.sub = 1'b1;
        alu_req.c   = alu_rsp.sum;
        alu_req.d   = hlen_q;
        f_we        = 1'b1;
        f_waddr     = '0;
        f_wdata     = '{start: base_q, len: (alu_rsp.lt ? alu_rsp.sum : hlen_q)};
        fc_d        = (f_wdata.len != '0) ? FCW'(1) : '0;
        uc_d        = '0;
        state_d     = S_DONE;
      end
      S_A_RD: begin
        if (idx_q == IW'(fc_q)) begin
          state_d = S_A_END;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        alu_req.c = f_rdata.len;
        alu_req.d = req_q;
        if (!alu_rsp.lt) begin
          pick_d  = idx_q[FAW-1:0];
          cur_d   = f_rdata;
          found_d = 1'b1;
        end
        idx_d   = idx_inc[IW-1:0];
        state_d = S_A_RD;
      end
      S_A_END: begin
        alu_req.a   = cur_q.len;
        alu_req.b   = req_q;
        alu_req.sub = 1'b1;
        tmp_d       = alu_rsp.sum;
        if (!found_q) begin
          status_d = ST_NO_FIT;
          state_d  = S_DONE;
        end else if (uc_q == UCW'(USED_ENTRIES)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_A_CARVE;
        end
      end
      S_A_CARVE: begin
        // block comes off the top end of the chosen region
        alu_req.a = {1'b0, cur_q.start};
        alu_req.b = tmp_q;
        grant_d   = alu_rsp.sum[AddrW-1:0];
        u_we      = 1'b1;
        u_waddr   = uc_q[UAW-1:0];
        u_wdata   = '{start: alu_rsp.sum[AddrW-1:0], len: req_q};
        uc_d      = uc_q + 1'b1;
        if (tmp_q != '0) begin
          f_we    = 1'b1;
          f_waddr = pick_q;
          f_wdata = '{start: cur_q.start, len: tmp_q};
          state_d = S_DONE;
        end else begin
          idx_d   = IW'(pick_q);
          state_d = S_RM_RD;
        end
      end
      S_RM_RD: begin
        f_raddr = idx_inc[FAW-1:0];
        if (idx_inc >= (IW+1)'(fc_q)) begin
          fc_d    = fc_q - 1'b1;
          state_d = (op_q == OP_FREE) ? S_REL_RD : S_DONE;
        end else begin
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        f_we    = 1'b1;
        f_waddr = idx_q[FAW-1:0];
        f_wdata = f_rdata;
        idx_d   = idx_inc[IW-1:0];
        state_d = S_RM_RD;
      end
      S_F_URD: begin
        if (idx_q == IW'(uc_q)) begin
          status_d = ST_UNKNOWN;
          state_d  = S_DONE;
        end else begin
          state_d = S_F_UCHK;
        end
      end
      S_F_UCHK: begin
        alu_req.c = {1'b0, u_rdata.start};
        alu_req.d = {1'b0, blk_q};
        if (alu_rsp.eq) begin
          u_d     = idx_q[UAW-1:0];
          cur_d   = u_rdata;
          state_d = S_F_END;
        end else begin
          idx_d   = idx_inc[IW-1:0];
          state_d = S_F_URD;
        end
      end
      S_F_END: begin
        alu_req.a = {1'b0, cur_q.start};
        alu_req.b = cur_q.len;
        end_d     = alu_rsp.sum;
        blk_d     = cur_q.start;
        req_d     = cur_q.len;
        idx_d     = '0;
        state_d   = S_F_RD;
      end
      S_F_RD: begin
        if (idx_q == IW'(fc_q)) begin
          state_d = S_F_INS;
        end else begin
          state_d = S_F_CHK;
        end
      end
      S_F_CHK: begin
        alu_req.a = {1'b0, f_rdata.start};
        alu_req.b = f_rdata.len;
        alu_req.e = {1'b0, blk_q};
        alu_req.c = end_q;
        alu_req.d = {1'b0, f_rdata.start};
        cur_d     = f_rdata;
        if (alu_rsp.lt) begin
          state_d = S_F_INS;
        end else if (alu_rsp.eq) begin
          state_d = S_F_MLO;
        end else if (alu_rsp.sum_eq) begin
          state_d = S_F_MHI;
        end else begin
          idx_d   = idx_inc[IW-1:0];
          state_d = S_F_RD;
        end
      end
      S_F_MLO: begin
        // merge with the region above
        alu_req.a = cur_q.len;
        alu_req.b = req_q;
        f_we      = 1'b1;
        f_wdata   = '{start: blk_q, len: alu_rsp.sum};
        state_d   = S_REL_RD;
      end
      S_F_MHI: begin
        // merge with the region below, maybe the one above too
        alu_req.a = cur_q.len;
        alu_req.b = req_q;
        tmp_d     = alu_rsp.sum;
        f_raddr   = idx_inc[FAW-1:0];
        if (idx_inc < (IW+1)'(fc_q)) begin
          state_d = S_F_MHI2;
        end else begin
          f_we    = 1'b1;
          f_wdata = '{start: cur_q.start, len: alu_rsp.sum};
          state_d = S_REL_RD;
        end
      end
      S_F_MHI2: begin
        alu_req.a = {1'b0, cur_q.start};
        alu_req.b = tmp_q;
        alu_req.e = {1'b0, f_rdata.start};
        nxt_d     = f_rdata.len;
        if (alu_rsp.sum_eq) begin
          state_d = S_F_MHI3;
        end else begin
          f_we    = 1'b1;
          f_wdata = '{start: cur_q.start, len: tmp_q};
          state_d = S_REL_RD;
        end
      end
      S_F_MHI3: begin
        alu_req.a = tmp_q;
        alu_req.b = nxt_q;
        f_we      = 1'b1;
        f_wdata   = '{start: cur_q.start, len: alu_rsp.sum};
        idx_d     = idx_inc[IW-1:0];
        state_d   = S_RM_RD;
      end
      S_F_INS: begin
        if (fc_q == FCW'(FREE_ENTRIES)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          k_d     = idx_q[FCW-1:0];
          idx_d   = IW'(fc_q);
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        f_raddr = FAW'(idx_q - 1'b1);
        if (idx_q == IW'(k_q)) begin
          f_we    = 1'b1;
          f_wdata = '{start: blk_q, len: req_q};
          fc_d    = fc_q + 1'b1;
          state_d = S_REL_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        f_we    = 1'b1;
        f_wdata = f_rdata;
        idx_d   = idx_q - 1'b1;
        state_d = S_INS_RD;
      end
      S_REL_RD: begin
        // last used entry fills the hole
        u_raddr = UAW'(uc_q - 1'b1);
        state_d = S_REL_WR;
      end
      S_REL_WR: begin
        u_we    = 1'b1;
        u_waddr = u_q;
        u_wdata = u_rdata;
        uc_d    = uc_q - 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{granted_address: grant_q, status: status_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_free_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FCW'(FREE_ENTRIES)) else $error("free count overflow");

  a_used_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc_q <= UCW'(USED_ENTRIES)) else $error("used count overflow");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.granted_address == '0)
    else $error("address granted on a failed beat");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("beat taken while busy");

endmodule

// ===== bench/tb_region_allocator_with_coalescing.sv =====
// self-checking bench for region_allocator_with_coalescing: random heap traffic, scoreboard
// keeps its own copy of the free and used tables; depends on ra_pkg and the rtl only
module tb_region_allocator_with_coalescing;
  import ra_pkg::*;

  localparam int unsigned NFREE = 64;
  localparam int unsigned NUSED = 64;

  typedef struct {
    ra_in_t beat;
    bit     live;
  } stim_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  ra_in_t          in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  ra_out_t         out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = 1'b0;
  logic [24:0]     cfg_data_i = '0;

  region_allocator_with_coalescing u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // heap shadow
  logic [AddrW-1:0] heap_base_q;
  logic [LenW-1:0]  heap_len_q;
  logic [AddrW-1:0] fr_start [NFREE];
  logic [LenW-1:0]  fr_len   [NFREE];
  int unsigned      fr_cnt;
  logic [AddrW-1:0] blk_start [NUSED];
  logic [LenW-1:0]  blk_len   [NUSED];
  int unsigned      blk_cnt;

  stim_t   stim_q[$];
  ra_out_t grant_q[$];
  int unsigned n_err, n_beats, n_grants, n_released, n_refused;
  bit calm;

  function automatic void heap_reinit();
    logic [LenW-1:0] room;
    logic [LenW-1:0] len;
    room = ADDR_SPACE - {1'b0, heap_base_q};
    len  = (heap_len_q > room) ? room : heap_len_q;
    blk_cnt = 0;
    fr_start[0] = heap_base_q;
    fr_len[0] = len;
    fr_cnt = (len != 0) ? 1 : 0;
  endfunction

  function automatic void drop_region(int unsigned idx);
    for (int unsigned k = idx; k + 1 < fr_cnt; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_len[k] = fr_len[k+1];
    end
    fr_cnt--;
  endfunction

  function automatic ra_status_e carve_block(logic [LenW-1:0] size,
                                             output logic [AddrW-1:0] addr);
    int unsigned pick;
    bit found;
    logic [LenW-1:0] top;
    pick = 0;
    found = 0;
    addr = '0;
    if (size == 0) return ST_NO_FIT;
    for (int unsigned k = 0; k < fr_cnt; k++)
      if (fr_len[k] >= size) begin
        pick = k;
        found = 1;
      end
    if (!found) return ST_NO_FIT;
    if (blk_cnt >= NUSED) return ST_FULL;
    top = {1'b0, fr_start[pick]} + fr_len[pick] - size;
    fr_len[pick] = fr_len[pick] - size;
    if (fr_len[pick] == 0) drop_region(pick);
    addr = top[AddrW-1:0];
    blk_start[blk_cnt] = addr;
    blk_len[blk_cnt] = size;
    blk_cnt++;
    return ST_OK;
  endfunction

  function automatic ra_status_e release_block(logic [AddrW-1:0] addr);
    int unsigned u, k, j;
    logic [AddrW-1:0] start;
    logic [LenW-1:0] size, stop_a, reg_end;
    bit merged;
    u = 0;
    while (u < blk_cnt && blk_start[u] != addr) u++;
    if (u >= blk_cnt) return ST_UNKNOWN;
    start = blk_start[u];
    size = blk_len[u];
    stop_a = {1'b0, start} + size;
    merged = 0;
    for (k = 0; k < fr_cnt; k++) begin
      reg_end = {1'b0, fr_start[k]} + fr_len[k];
      if (stop_a < {1'b0, fr_start[k]}) break;
      if (stop_a == {1'b0, fr_start[k]}) begin
        fr_start[k] = start;
        fr_len[k] = fr_len[k] + size;
        merged = 1;
        break;
      end
      if (reg_end == {1'b0, start}) begin
        fr_len[k] = fr_len[k] + size;
        if (k + 1 < fr_cnt &&
            {1'b0, fr_start[k]} + fr_len[k] == {1'b0, fr_start[k+1]}) begin
          fr_len[k] = fr_len[k] + fr_len[k+1];
          drop_region(k + 1);
        end
        merged = 1;
        break;
      end
    end
    if (!merged) begin
      if (fr_cnt >= NFREE) return ST_FULL;
      for (j = fr_cnt; j > k; j--) begin
        fr_start[j] = fr_start[j-1];
        fr_len[j] = fr_len[j-1];
      end
      fr_start[k] = start;
      fr_len[k] = size;
      fr_cnt++;
    end
    blk_cnt--;
    blk_start[u] = blk_start[blk_cnt];
    blk_len[u] = blk_len[blk_cnt];
    return ST_OK;
  endfunction

  function automatic ra_out_t heap_step(ra_in_t b);
    ra_out_t r;
    logic [AddrW-1:0] a;
    r = '0;
    a = '0;
    case (ra_op_e'(b.opcode))
      OP_INIT:  heap_reinit();
      OP_ALLOC: begin
        r.status = carve_block(b.request_bytes, a);
        r.granted_address = a;
      end
      OP_FREE:  r.status = release_block(b.block_address);
      default:  ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t s;
    ra_in_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left = 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i && in_ready_o) begin
        grant_q.push_back(heap_step(in_data_i));
        n_beats++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (stim_q.size() > 0) begin
        s = stim_q.pop_front();
        b = s.beat;
        if (s.live && blk_cnt > 0) b.block_address = blk_start[$urandom_range(0, blk_cnt-1)];
        in_data_i <= b;
        in_valid_i <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    ra_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (grant_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result beat: addr %h status %0d",
                                    out_data_o.granted_address, out_data_o.status);
        end else begin
          want = grant_q.pop_front();
          if (want.status == ST_OK && out_data_o.granted_address != 0) n_grants++;
          if (want.status != ST_OK) n_refused++;
          if (out_data_o.granted_address != want.granted_address ||
              out_data_o.status != want.status) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       want.granted_address, want.status,
                       out_data_o.granted_address, out_data_o.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || grant_q.size() != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [24:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    if (idx == REG_HEAP_BASE) heap_base_q = val[AddrW-1:0];
    else heap_len_q = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_beat(ra_op_e op, logic [LenW-1:0] req, logic [AddrW-1:0] addr, bit live);
    stim_t s;
    s.beat.opcode = op;
    s.beat.request_bytes = req;
    s.beat.block_address = addr;
    s.live = live;
    stim_q.push_back(s);
  endtask

  task automatic add_random(int unsigned n);
    int unsigned r;
    logic [LenW-1:0] sz;
    logic [LenW-1:0] rq;
    logic [AddrW-1:0] ra;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      sz = $urandom_range(0, 99) < 70 ? LenW'($urandom_range(1, 64)) :
           $urandom_range(0, 99) < 60 ? LenW'($urandom_range(1, 1 << $urandom_range(6, 24))) :
           $urandom_range(0, 9) == 0 ? LenW'(0) : LenW'($urandom());
      rq = LenW'($urandom());
      ra = AddrW'($urandom());
      if (r < 48) add_beat(OP_ALLOC, sz, ra, 0);
      else if (r < 88) add_beat(OP_FREE, rq, ra, 1);
      else if (r < 94) add_beat(OP_FREE, rq, ra, 0);
      else if (r < 97) add_beat(OP_NOP, rq, ra, 0);
      else add_beat(OP_INIT, rq, ra, 0);
    end
  endtask

  logic [24:0] set_base [7] = '{25'h801000, 25'h0, 25'hFFFF00, 25'h123456,
                                25'h0, 25'hFFFFFF, 25'h0};
  logic [24:0] set_len  [7] = '{25'h7FF000, 25'h1000000, 25'h1FFFFFF, 25'h0,
                                25'h100, 25'h1, 25'h1000};
  int unsigned set_items [7] = '{300, 300, 250, 60, 450, 80, 450};

  initial begin
    heap_base_q = RST_HEAP_BASE;
    heap_len_q = RST_HEAP_LENGTH;
    heap_reinit();
    calm = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero size, no fit, whole heap, empty table, merges, unknown address, ignored opcode
    add_beat(OP_ALLOC, 25'h0, 24'h0, 0);
    add_beat(OP_ALLOC, 25'h1FFFFFF, 24'hFFFFFF, 0);
    add_beat(OP_ALLOC, 25'h7FF000, 24'h0, 0);
    add_beat(OP_ALLOC, 25'h1, 24'h0, 0);
    add_beat(OP_FREE, 25'h0, 24'h0, 1);
    add_beat(OP_FREE, 25'h1FFFFFF, 24'hFFFFFF, 0);
    add_beat(OP_FREE, 25'h0, 24'h0, 0);
    repeat (4) add_beat(OP_ALLOC, 25'h1000, 24'h0, 0);
    repeat (4) add_beat(OP_FREE, 25'h0, 24'h0, 1);
    add_beat(OP_NOP, 25'h1FFFFFF, 24'hFFFFFF, 0);
    add_beat(OP_NOP, 25'h0, 24'h0, 0);
    add_beat(OP_ALLOC, 25'h1000000, 24'h0, 0);
    add_beat(OP_INIT, 25'h1FFFFFF, 24'hFFFFFF, 0);
    add_beat(OP_ALLOC, 25'h7FF001, 24'h0, 0);
    add_beat(OP_ALLOC, 25'h1, 24'h0, 0);
    add_beat(OP_FREE, 25'h0, 24'h0, 1);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_HEAP_BASE, set_base[p]);
      write_reg(REG_HEAP_LENGTH, set_len[p]);
      calm = (p % 3 == 1);
      add_beat(OP_INIT, '0, '0, 0);
      add_random(set_items[p]);
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    if (grant_q.size() != 0) n_err++;
    $display("%0d beats over 8 heap settings: %0d grants, %0d refusals, %0d errors",
             n_beats, n_grants, n_refused, n_err);
    if (n_err == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ra_pkg.sv
rtl/ra_alu.sv
rtl/ra_tbl.sv
rtl/region_allocator_with_coalescing.sv
bench/tb_region_allocator_with_coalescing.sv
